>>> src/assert_macros.svh
// Assertion macros shared by the scanner RTL.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define ASSERT_PROP(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Implication that must hold at every clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_PROP(label, prop)
`define ASSERT_IMPL(label, ante, cons)
`endif
`endif

>>> src/eesc_pkg.sv
// Shared types, character codes and helpers of the expression extent scanner.
// Depends on nothing.
`timescale 1ns / 1ps

package eesc_pkg;

  // Default parameter values.
  localparam int unsigned DEF_MAX_DEPTH  = 255;
  localparam int unsigned DEF_MAX_LENGTH = 65535;

  // Character codes.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_BQUOTE = 8'h60;

  // Quote kinds.
  localparam logic [1:0] QK_DOUBLE = 2'd0;
  localparam logic [1:0] QK_SINGLE = 2'd1;
  localparam logic [1:0] QK_BACK   = 2'd2;

  // Result kinds.
  localparam logic [2:0] KIND_ATOM      = 3'd0;
  localparam logic [2:0] KIND_LIST      = 3'd1;
  localparam logic [2:0] KIND_QUOTE     = 3'd2;
  localparam logic [2:0] KIND_QUOTE_NUL = 3'd3;
  localparam logic [2:0] KIND_BUF_END   = 3'd4;

  // Scan modes, one-hot.
  typedef enum logic [10:0] {
    M_IDLE      = 11'b000_0000_0001,
    M_SKIP      = 11'b000_0000_0010,
    M_COMMENT   = 11'b000_0000_0100,
    M_LIST      = 11'b000_0000_1000,
    M_LSTR      = 11'b000_0001_0000,
    M_LSTR_ESC  = 11'b000_0010_0000,
    M_QUOTE     = 11'b000_0100_0000,
    M_QUOTE_ESC = 11'b000_1000_0000,
    M_ATOM      = 11'b001_0000_0000,
    M_WAIT_END  = 11'b010_0000_0000,
    M_DONE      = 11'b100_0000_0000
  } scan_mode_t;

  // Mode and open quote kind, passed between the top level and the step logic.
  typedef struct packed {
    scan_mode_t mode;
    logic [1:0] qkind;
  } scan_ctrl_t;

  // Input word: one character of the buffer.
  typedef struct packed {
    logic [7:0] char_in;
    logic       first_of_buffer;
    logic       last_of_buffer;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [15:0] end_offset;
    logic [2:0]  end_kind;
  } out_word_t;

  // Space and the control characters tab through carriage return.
  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // Closing character of a quote kind.
  function automatic logic [7:0] quote_char(input logic [1:0] k);
    logic [7:0] ch;
    case (k)
      QK_SINGLE: ch = CH_SQUOTE;
      QK_BACK:   ch = CH_BQUOTE;
      default:   ch = CH_DQUOTE;
    endcase
    return ch;
  endfunction

endpackage

>>> src/eesc_step.sv
// Next-state and result logic of the scanner for one character.
// Depends on eesc_pkg.
`timescale 1ns / 1ps

module eesc_step #(
  parameter int unsigned MAX_DEPTH  = eesc_pkg::DEF_MAX_DEPTH,
  parameter int unsigned MAX_LENGTH = eesc_pkg::DEF_MAX_LENGTH,
  localparam int unsigned DW        = $clog2(MAX_DEPTH + 1)
) (
  input  eesc_pkg::in_word_t   word,
  input  eesc_pkg::scan_ctrl_t ctrl_cur,
  input  logic [DW-1:0]        depth_cur,
  input  logic [15:0]          pos_cur,
  output eesc_pkg::scan_ctrl_t ctrl_nxt,
  output logic [DW-1:0]        depth_nxt,
  output logic [15:0]          pos_nxt,
  output logic                 found,
  output eesc_pkg::out_word_t  result
);

  localparam logic [15:0] POS_LIMIT =
    (MAX_LENGTH < 32'd65535) ? 16'(MAX_LENGTH) : 16'hFFFF;
  localparam logic [DW-1:0] DEPTH_MAX = DW'(MAX_DEPTH);

  logic [7:0]  c;
  logic        active;
  logic        quote_go;
  logic        consumed;
  logic [15:0] pos_inc;

  assign c = word.char_in;

  always_comb begin
    ctrl_nxt  = ctrl_cur;
    depth_nxt = depth_cur;
    pos_nxt   = pos_cur;
    active    = 1'b1;
    quote_go  = 1'b0;
    consumed  = 1'b0;
    found     = 1'b0;
    result    = '0;

    // A first character restarts the scan; strays outside a buffer are dropped.
    if (word.first_of_buffer) begin
      ctrl_nxt.mode  = eesc_pkg::M_SKIP;
      ctrl_nxt.qkind = eesc_pkg::QK_DOUBLE;
      depth_nxt      = '0;
      pos_nxt        = '0;
    end else if (ctrl_cur.mode == eesc_pkg::M_IDLE || ctrl_cur.mode == eesc_pkg::M_DONE) begin
      active = 1'b0;
    end

    // Offset one past the current character, saturated.
    pos_inc = (pos_nxt < POS_LIMIT) ? pos_nxt + 16'd1 : POS_LIMIT;

    if (active) begin
      unique case (ctrl_nxt.mode)
        eesc_pkg::M_SKIP: begin
          if (!eesc_pkg::is_space(c)) begin
            if (c == eesc_pkg::CH_SEMI) begin
              ctrl_nxt.mode = eesc_pkg::M_COMMENT;
            end else if (c == eesc_pkg::CH_LPAREN) begin
              ctrl_nxt.mode = eesc_pkg::M_LIST;
              depth_nxt     = DW'(1);
            end else if (c == eesc_pkg::CH_DQUOTE) begin
              ctrl_nxt.mode  = eesc_pkg::M_QUOTE;
              ctrl_nxt.qkind = eesc_pkg::QK_DOUBLE;
            end else if (c == eesc_pkg::CH_SQUOTE) begin
              ctrl_nxt.mode  = eesc_pkg::M_QUOTE;
              ctrl_nxt.qkind = eesc_pkg::QK_SINGLE;
            end else if (c == eesc_pkg::CH_BQUOTE) begin
              ctrl_nxt.mode  = eesc_pkg::M_QUOTE;
              ctrl_nxt.qkind = eesc_pkg::QK_BACK;
            end else begin
              ctrl_nxt.mode = eesc_pkg::M_ATOM;
            end
          end
        end
        eesc_pkg::M_COMMENT: begin
          if (c == eesc_pkg::CH_LF) begin
            ctrl_nxt.mode = eesc_pkg::M_SKIP;
          end else if (c == eesc_pkg::CH_NUL) begin
            ctrl_nxt.mode = eesc_pkg::M_WAIT_END;
          end
        end
        eesc_pkg::M_LIST: begin
          if (c == eesc_pkg::CH_LPAREN) begin
            if (depth_nxt < DEPTH_MAX) begin
              depth_nxt = depth_nxt + DW'(1);
            end
          end else if (c == eesc_pkg::CH_RPAREN) begin
            if (depth_nxt != '0) begin
              depth_nxt = depth_nxt - DW'(1);
              if (depth_nxt == '0) begin
                found           = 1'b1;
                result.end_offset = pos_inc;
                result.end_kind   = eesc_pkg::KIND_LIST;
              end
            end
          end else if (c == eesc_pkg::CH_DQUOTE) begin
            ctrl_nxt.mode = eesc_pkg::M_LSTR;
          end
        end
        eesc_pkg::M_LSTR: begin
          if (c == eesc_pkg::CH_DQUOTE || c == eesc_pkg::CH_NUL) begin
            ctrl_nxt.mode = eesc_pkg::M_LIST;
          end else if (c == eesc_pkg::CH_BSLASH) begin
            ctrl_nxt.mode = eesc_pkg::M_LSTR_ESC;
          end
        end
        eesc_pkg::M_LSTR_ESC: begin
          ctrl_nxt.mode = (c == eesc_pkg::CH_NUL) ? eesc_pkg::M_LIST : eesc_pkg::M_LSTR;
        end
        eesc_pkg::M_QUOTE_ESC: begin
          // Single quotes escape only backslash, quote and hash.
          ctrl_nxt.mode = eesc_pkg::M_QUOTE;
          if (ctrl_nxt.qkind == eesc_pkg::QK_SINGLE) begin
            consumed = (c == eesc_pkg::CH_BSLASH) || (c == eesc_pkg::CH_SQUOTE) ||
                       (c == eesc_pkg::CH_HASH);
          end else begin
            consumed = (c != eesc_pkg::CH_NUL);
          end
          quote_go = !consumed;
        end
        eesc_pkg::M_QUOTE: begin
          quote_go = 1'b1;
        end
        eesc_pkg::M_ATOM: begin
          if (eesc_pkg::is_space(c)) begin
            found             = 1'b1;
            result.end_offset = pos_nxt;
            result.end_kind   = eesc_pkg::KIND_ATOM;
          end
        end
        default: begin
        end
      endcase

      // An ordinary character inside a top-level quoted string.
      if (quote_go) begin
        if (c == eesc_pkg::quote_char(ctrl_nxt.qkind)) begin
          found             = 1'b1;
          result.end_offset = pos_inc;
          result.end_kind   = eesc_pkg::KIND_QUOTE;
        end else if (c == eesc_pkg::CH_NUL) begin
          found             = 1'b1;
          result.end_offset = pos_nxt;
          result.end_kind   = eesc_pkg::KIND_QUOTE_NUL;
        end else if (c == eesc_pkg::CH_BSLASH) begin
          ctrl_nxt.mode = eesc_pkg::M_QUOTE_ESC;
        end
      end

      // The buffer end decides when nothing else did.
      if (!found && word.last_of_buffer) begin
        found             = 1'b1;
        result.end_offset = pos_inc;
        result.end_kind   = eesc_pkg::KIND_BUF_END;
      end

      pos_nxt = pos_inc;
      if (found) begin
        ctrl_nxt.mode = eesc_pkg::M_DONE;
      end
    end
  end

endmodule

>>> src/expression_extent_scanner.sv
// Top level of the expression extent scanner: input register, scan state,
// result register. Depends on eesc_pkg, eesc_step and assert_macros.svh.
`timescale 1ns / 1ps
//
//  Channel   Ports                           Word
//  -------   -----------------------------   ----------------------------
//  input     in_valid, in_ready, in_word     char_in, first/last_of_buffer
//  result    out_valid, out_ready, out_word  end_offset, end_kind
//
//  One character is taken per cycle when the result side keeps up; out_valid
//  rises when the step logic loads the result for the character that decides it.
//  The character passes an input register, then one step of scan logic
//  updates the state and loads the result register.
//  Reset clears the scan to idle and empties both registers.
//  A result held by a stalled consumer stops the input register from moving.
`include "assert_macros.svh"

module expression_extent_scanner #(
  parameter int unsigned MAX_DEPTH  = eesc_pkg::DEF_MAX_DEPTH,
  parameter int unsigned MAX_LENGTH = eesc_pkg::DEF_MAX_LENGTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  eesc_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output eesc_pkg::out_word_t out_word
);

  localparam int unsigned DW = $clog2(MAX_DEPTH + 1);
  localparam logic [15:0] POS_LIMIT =
    (MAX_LENGTH < 32'd65535) ? 16'(MAX_LENGTH) : 16'hFFFF;

  logic                 in_valid_r, in_valid_nxt;
  eesc_pkg::in_word_t   in_word_r, in_word_nxt;
  eesc_pkg::scan_ctrl_t ctrl_r, ctrl_nxt;
  logic [DW-1:0]        depth_r, depth_nxt;
  logic [15:0]          pos_r, pos_nxt;
  logic                 out_valid_r, out_valid_nxt;
  eesc_pkg::out_word_t  out_word_r, out_word_nxt;

  eesc_pkg::scan_ctrl_t step_ctrl;
  logic [DW-1:0]        step_depth;
  logic [15:0]          step_pos;
  logic                 step_found;
  eesc_pkg::out_word_t  step_result;
  logic                 advance;
  logic                 list_mode;

  // The held word moves on when the result register is free or draining.
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  eesc_step #(
    .MAX_DEPTH  (MAX_DEPTH),
    .MAX_LENGTH (MAX_LENGTH)
  ) u_step (
    .word      (in_word_r),
    .ctrl_cur  (ctrl_r),
    .depth_cur (depth_r),
    .pos_cur   (pos_r),
    .ctrl_nxt  (step_ctrl),
    .depth_nxt (step_depth),
    .pos_nxt   (step_pos),
    .found     (step_found),
    .result    (step_result)
  );

  // Next values of input register, scan state and result register.
  always_comb begin
    in_valid_nxt  = in_valid_r;
    in_word_nxt   = in_word_r;
    ctrl_nxt      = ctrl_r;
    depth_nxt     = depth_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_word_nxt  = out_word_r;

    if (advance) begin
      in_valid_nxt = 1'b0;
      ctrl_nxt     = step_ctrl;
      depth_nxt    = step_depth;
      pos_nxt      = step_pos;
      if (step_found) begin
        out_valid_nxt = 1'b1;
        out_word_nxt  = step_result;
      end
    end
    if (in_valid && in_ready) begin
      in_valid_nxt = 1'b1;
      in_word_nxt  = in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      ctrl_r.mode  <= eesc_pkg::M_IDLE;
      ctrl_r.qkind <= eesc_pkg::QK_DOUBLE;
      depth_r      <= '0;
      pos_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      ctrl_r      <= ctrl_nxt;
      depth_r     <= depth_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    in_word_r  <= in_word_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // The scan is inside a list or a string within a list.
  assign list_mode = (ctrl_r.mode == eesc_pkg::M_LIST) || (ctrl_r.mode == eesc_pkg::M_LSTR) ||
                     (ctrl_r.mode == eesc_pkg::M_LSTR_ESC);

  // Checks on the scan state and the results.
  `ASSERT_IMPL(a_kind_range, out_valid_r, out_word_r.end_kind <= eesc_pkg::KIND_BUF_END)
  `ASSERT_PROP(a_depth_bound, depth_r <= DW'(MAX_DEPTH))
  `ASSERT_PROP(a_pos_bound, pos_r <= POS_LIMIT)
  `ASSERT_IMPL(a_list_open, list_mode, depth_r != '0)
  `ASSERT_IMPL(a_result_done, advance && step_found, step_ctrl.mode == eesc_pkg::M_DONE)

endmodule
